@@ sv/i2cmte_pkg.sv @@
// Shared types and constants for the I2C master transaction engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package i2cmte_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_ENQUEUE = 2'd1;
  localparam cmd_t CMD_EVENT   = 2'd2;

  typedef logic [2:0] action_t;
  localparam action_t ACT_NONE     = 3'd0;
  localparam action_t ACT_START    = 3'd1;
  localparam action_t ACT_SEND     = 3'd2;
  localparam action_t ACT_RECV_ACK = 3'd3;
  localparam action_t ACT_RECV_NAK = 3'd4;
  localparam action_t ACT_STOP     = 3'd5;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OC_OK         = 2'd0;
  localparam outcome_t OC_START_FAIL = 2'd1;
  localparam outcome_t OC_ADDR_NACK  = 2'd2;
  localparam outcome_t OC_DATA_FAIL  = 2'd3;

  localparam logic [7:0] BS_MASK         = 8'hF8;
  localparam logic [7:0] BS_START        = 8'h08;
  localparam logic [7:0] BS_RESTART      = 8'h10;
  localparam logic [7:0] BS_ADDR_W_ACK   = 8'h18;
  localparam logic [7:0] BS_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] BS_ADDR_R_ACK   = 8'h40;
  localparam logic [7:0] BS_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] BS_DATA_RX_NACK = 8'h58;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE  = 2'd0;
  localparam phase_t PH_START = 2'd1;
  localparam phase_t PH_ADDR  = 2'd2;
  localparam phase_t PH_DATA  = 2'd3;

  typedef struct packed {
    logic       link;
    logic       stop;
    logic [4:0] count;
    logic       rw;
    logic [6:0] addr;
  } desc_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic enq_ok;
    logic enq_rej;
    logic event_go;
    logic drop;
    logic start;
    logic fin;
    logic fin_last;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic busy;
    logic ev_end;
    logic ev_drop;
    logic drop_more;
  } dp_stat_t;

endpackage

@@ sv/i2c_master_transaction_engine.sv @@
// Channel   Direction  Beat content
// in_*      input      command with descriptor, write byte or bus status event
// out_*     output     bus action, received byte report, completion status
//
// A write byte load or an unused command is decoded and returns to idle; an enqueue or a bus
// event is decoded and may start the next descriptor, and a bus fault also drops each linked
// descriptor behind it; every result waits in the output register until taken. One beat is in
// work at a time: the next is accepted after the last result of the previous one has been
// taken. Reset (rst_n low, synchronous) empties the descriptor ring and idles the engine; the
// ring and byte store contents stay undefined until written.
// Top level; instantiates i2cmte_ctrl and i2cmte_datapath, uses i2cmte_pkg.
module i2c_master_transaction_engine #(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_BYTES   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_target_address,
  input  logic       in_read_not_write,
  input  logic [4:0] in_byte_count,
  input  logic       in_send_stop,
  input  logic       in_linked_to_next,
  input  logic [3:0] in_load_index,
  input  logic [7:0] in_load_value,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_bus_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_bus_action,
  output logic [7:0] out_tx_byte,
  output logic       out_rx_valid,
  output logic [3:0] out_rx_index,
  output logic [7:0] out_rx_byte,
  output logic       out_done_res,
  output logic [1:0] out_outcome,
  output logic [3:0] out_bytes_before_error,
  output logic [7:0] out_bus_error_code,
  output logic       out_notify,
  output logic       out_enqueue_rejected,
  output logic       out_last
);
  import i2cmte_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  i2cmte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  i2cmte_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BYTES   (MAX_BYTES)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (dp_cmd),
    .stat                   (dp_stat),
    .in_command             (in_command),
    .in_target_address      (in_target_address),
    .in_read_not_write      (in_read_not_write),
    .in_byte_count          (in_byte_count),
    .in_send_stop           (in_send_stop),
    .in_linked_to_next      (in_linked_to_next),
    .in_load_index          (in_load_index),
    .in_load_value          (in_load_value),
    .in_bus_status          (in_bus_status),
    .in_bus_data            (in_bus_data),
    .out_bus_action         (out_bus_action),
    .out_tx_byte            (out_tx_byte),
    .out_rx_valid           (out_rx_valid),
    .out_rx_index           (out_rx_index),
    .out_rx_byte            (out_rx_byte),
    .out_done_res           (out_done_res),
    .out_outcome            (out_outcome),
    .out_bytes_before_error (out_bytes_before_error),
    .out_bus_error_code     (out_bus_error_code),
    .out_notify             (out_notify),
    .out_enqueue_rejected   (out_enqueue_rejected),
    .out_last               (out_last)
  );

endmodule

@@ sv/i2cmte_datapath.sv @@
// Datapath of the I2C master transaction engine: descriptor ring, write byte store,
// active transaction registers, bus event evaluation and the result register.
// Depends on i2cmte_pkg.
module i2cmte_datapath #(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_BYTES   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cmte_pkg::dp_cmd_t  cmd,
  output i2cmte_pkg::dp_stat_t stat,
  input  logic [1:0]           in_command,
  input  logic [6:0]           in_target_address,
  input  logic                 in_read_not_write,
  input  logic [4:0]           in_byte_count,
  input  logic                 in_send_stop,
  input  logic                 in_linked_to_next,
  input  logic [3:0]           in_load_index,
  input  logic [7:0]           in_load_value,
  input  logic [7:0]           in_bus_status,
  input  logic [7:0]           in_bus_data,
  output logic [2:0]           out_bus_action,
  output logic [7:0]           out_tx_byte,
  output logic                 out_rx_valid,
  output logic [3:0]           out_rx_index,
  output logic [7:0]           out_rx_byte,
  output logic                 out_done_res,
  output logic [1:0]           out_outcome,
  output logic [3:0]           out_bytes_before_error,
  output logic [7:0]           out_bus_error_code,
  output logic                 out_notify,
  output logic                 out_enqueue_rejected,
  output logic                 out_last
);
  import i2cmte_pkg::*;

  localparam int QW       = $clog2(QUEUE_DEPTH);
  localparam int BW       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int SD       = QUEUE_DEPTH * (2 ** BW);
  localparam int SAW      = QW + BW;

  typedef logic [QW-1:0] qidx_t;

  function automatic qidx_t next_idx(input qidx_t p);
    if (p == QW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  cmd_t       cmd_r;
  logic [6:0] addr_r;
  logic       rw_r;
  logic [4:0] cnt_r;
  logic       stop_r;
  logic       link_r;
  logic [3:0] lidx_r;
  logic [7:0] lval_r;
  logic [7:0] status_r;
  logic [7:0] data_r;

  qidx_t      head_r;
  qidx_t      tail_r;
  logic       busy_r;
  phase_t     phase_r;
  logic [4:0] bytes_done_r;
  desc_t      active_r;
  qidx_t      slot_r;

  desc_t      ring_mem [QUEUE_DEPTH];
  desc_t      ring_rd_r;
  logic [7:0] store_mem [SD];
  logic [7:0] store_rd_r;

  action_t    act_r;
  logic [7:0] tx_r;
  logic       rxv_r;
  logic [3:0] rxi_r;
  logic [7:0] rxb_r;
  logic       done_r;
  outcome_t   outc_r;
  logic [3:0] bbe_r;
  logic [7:0] err_r;
  logic       note_r;
  logic       rej_r;
  logic       last_r;

  action_t    ev_act;
  logic [7:0] ev_tx;
  logic       ev_rxv;
  logic [3:0] ev_rxi;
  logic [7:0] ev_rxb;
  logic       ev_done;
  outcome_t   ev_outc;
  logic [3:0] ev_bbe;
  logic [7:0] ev_err;
  logic       ev_note;
  logic       ev_busy;
  phase_t     ev_phase;
  logic [4:0] ev_bytes;
  logic       ev_fail;
  logic       ev_adv;
  logic [4:0] bytes_m1;
  logic [4:0] cnt_sat;
  desc_t      new_desc;
  logic       load_ok;
  logic [SAW-1:0] load_addr;
  logic [SAW-1:0] rd_addr;

  assign bytes_m1  = bytes_done_r - 5'd1;
  assign cnt_sat   = (32'(cnt_r) > MAX_BYTES) ? 5'(MAX_BYTES) : cnt_r;
  assign new_desc  = '{link: link_r, stop: stop_r, count: cnt_sat, rw: rw_r, addr: addr_r};
  assign load_ok   = (32'(lidx_r) < MAX_BYTES) && !(busy_r && (tail_r == slot_r));
  assign load_addr = {tail_r, BW'(lidx_r)};
  assign rd_addr   = {slot_r, BW'(bytes_done_r)};

  always_comb begin
    ev_act   = ACT_NONE;
    ev_tx    = '0;
    ev_rxv   = 1'b0;
    ev_rxi   = '0;
    ev_rxb   = '0;
    ev_done  = 1'b0;
    ev_outc  = OC_OK;
    ev_bbe   = '0;
    ev_err   = '0;
    ev_note  = 1'b0;
    ev_busy  = busy_r;
    ev_phase = phase_r;
    ev_bytes = bytes_done_r;
    ev_fail  = 1'b0;
    ev_adv   = 1'b0;
    case (phase_r)
      PH_START: begin
        if (status_r != BS_START && status_r != BS_RESTART) begin
          ev_fail = 1'b1;
          ev_outc = OC_START_FAIL;
        end else begin
          ev_phase = PH_ADDR;
          ev_act   = ACT_SEND;
          ev_tx    = {active_r.addr, active_r.rw};
        end
      end
      PH_ADDR: begin
        if ((!active_r.rw && status_r != BS_ADDR_W_ACK) ||
            (active_r.rw && status_r != BS_ADDR_R_ACK)) begin
          ev_fail = 1'b1;
          ev_outc = OC_ADDR_NACK;
        end else begin
          ev_adv = 1'b1;
        end
      end
      PH_DATA: begin
        if ((!active_r.rw && status_r != BS_DATA_TX_ACK) ||
            (active_r.rw && status_r != BS_DATA_RX_ACK && status_r != BS_DATA_RX_NACK)) begin
          ev_fail = 1'b1;
          ev_outc = OC_DATA_FAIL;
        end else begin
          ev_adv = 1'b1;
          if (active_r.rw) begin
            ev_rxv = 1'b1;
            ev_rxi = bytes_m1[3:0];
            ev_rxb = data_r;
          end
        end
      end
      default: begin
        ev_adv = 1'b1;
      end
    endcase
    if (ev_fail) begin
      ev_act   = ACT_STOP;
      ev_done  = 1'b1;
      ev_err   = status_r;
      ev_note  = 1'b1;
      ev_busy  = 1'b0;
      ev_phase = PH_IDLE;
      if (ev_outc == OC_DATA_FAIL) begin
        ev_bbe = bytes_m1[3:0];
      end
    end
    if (ev_adv) begin
      if (bytes_done_r < active_r.count) begin
        ev_phase = PH_DATA;
        if (!active_r.rw) begin
          ev_act = ACT_SEND;
          ev_tx  = store_rd_r;
        end else begin
          ev_act = ((bytes_done_r + 5'd1) == active_r.count) ? ACT_RECV_NAK : ACT_RECV_ACK;
        end
        ev_bytes = bytes_done_r + 5'd1;
      end else begin
        ev_act   = active_r.stop ? ACT_STOP : ACT_NONE;
        ev_done  = 1'b1;
        ev_note  = !active_r.link;
        ev_busy  = 1'b0;
        ev_phase = PH_IDLE;
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.full      = (next_idx(tail_r) == head_r);
    stat.empty     = (head_r == tail_r);
    stat.busy      = busy_r;
    stat.ev_end    = !ev_busy;
    stat.ev_drop   = ev_fail && active_r.link && (head_r != tail_r);
    stat.drop_more = ring_rd_r.link && (next_idx(head_r) != tail_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_command;
      addr_r   <= in_target_address;
      rw_r     <= in_read_not_write;
      cnt_r    <= in_byte_count;
      stop_r   <= in_send_stop;
      link_r   <= in_linked_to_next;
      lidx_r   <= in_load_index;
      lval_r   <= in_load_value;
      status_r <= in_bus_status & BS_MASK;
      data_r   <= in_bus_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_ok) begin
      ring_mem[tail_r] <= new_desc;
    end
    ring_rd_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      store_mem[load_addr] <= lval_r;
    end
    store_rd_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      busy_r       <= 1'b0;
      phase_r      <= PH_IDLE;
      bytes_done_r <= '0;
      active_r     <= '0;
      slot_r       <= '0;
    end else begin
      if (cmd.enq_ok) begin
        tail_r <= next_idx(tail_r);
      end
      if (cmd.drop) begin
        head_r <= next_idx(head_r);
      end
      if (cmd.event_go) begin
        busy_r       <= ev_busy;
        phase_r      <= ev_phase;
        bytes_done_r <= ev_bytes;
      end
      if (cmd.start) begin
        active_r     <= ring_rd_r;
        slot_r       <= head_r;
        head_r       <= next_idx(head_r);
        busy_r       <= 1'b1;
        phase_r      <= PH_START;
        bytes_done_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.enq_ok || cmd.enq_rej) begin
      act_r  <= cmd.start ? ACT_START : ACT_NONE;
      tx_r   <= '0;
      rxv_r  <= 1'b0;
      rxi_r  <= '0;
      rxb_r  <= '0;
      done_r <= 1'b0;
      outc_r <= OC_OK;
      bbe_r  <= '0;
      err_r  <= '0;
      note_r <= 1'b0;
      rej_r  <= cmd.enq_rej;
      last_r <= 1'b1;
    end else if (cmd.event_go) begin
      act_r  <= ev_act;
      tx_r   <= ev_tx;
      rxv_r  <= ev_rxv;
      rxi_r  <= ev_rxi;
      rxb_r  <= ev_rxb;
      done_r <= ev_done;
      outc_r <= ev_outc;
      bbe_r  <= ev_bbe;
      err_r  <= ev_err;
      note_r <= ev_note;
      rej_r  <= 1'b0;
    end
    if (cmd.fin) begin
      last_r <= cmd.fin_last;
    end
  end

  assign out_bus_action         = act_r;
  assign out_tx_byte            = tx_r;
  assign out_rx_valid           = rxv_r;
  assign out_rx_index           = rxi_r;
  assign out_rx_byte            = rxb_r;
  assign out_done_res           = done_r;
  assign out_outcome            = outc_r;
  assign out_bytes_before_error = bbe_r;
  assign out_bus_error_code     = err_r;
  assign out_notify             = note_r;
  assign out_enqueue_rejected   = rej_r;
  assign out_last               = last_r;

  a_busy_has_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> phase_r != PH_IDLE)
    else $error("busy engine without an active phase");

  a_idle_no_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> phase_r == PH_IDLE)
    else $error("idle engine holds a phase");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> bytes_done_r <= active_r.count)
    else $error("byte counter ran past the transaction length");

endmodule

@@ sv/i2cmte_ctrl.sv @@
// Controller state machine of the I2C master transaction engine.
// Sequences the datapath through decode, start, drop walk and result delivery; uses i2cmte_pkg.
module i2cmte_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cmte_pkg::dp_cmd_t  cmd,
  input  i2cmte_pkg::dp_stat_t stat
);
  import i2cmte_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_DECODE     = 8'b0000_0010,
    ST_START_WAIT = 8'b0000_0100,
    ST_START      = 8'b0000_1000,
    ST_DROP_WAIT  = 8'b0001_0000,
    ST_DROP       = 8'b0010_0000,
    ST_CHECK      = 8'b0100_0000,
    ST_OUT        = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   ended_r;
  logic   ended_nxt;
  logic   pend_r;
  logic   pend_nxt;

  always_comb begin
    state_nxt = state_r;
    ended_nxt = ended_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_LOAD: begin
            cmd.load  = 1'b1;
            state_nxt = ST_IDLE;
          end
          CMD_ENQUEUE: begin
            pend_nxt = 1'b0;
            if (stat.full) begin
              cmd.enq_rej = 1'b1;
              state_nxt   = ST_OUT;
            end else begin
              cmd.enq_ok = 1'b1;
              state_nxt  = stat.busy ? ST_OUT : ST_START_WAIT;
            end
          end
          CMD_EVENT: begin
            if (!stat.busy) begin
              state_nxt = stat.empty ? ST_IDLE : ST_START_WAIT;
            end else begin
              cmd.event_go = 1'b1;
              ended_nxt    = stat.ev_end;
              state_nxt    = stat.ev_drop ? ST_DROP_WAIT : ST_CHECK;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_START_WAIT: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = ST_OUT;
      end
      ST_DROP_WAIT: begin
        state_nxt = ST_DROP;
      end
      ST_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = stat.drop_more ? ST_DROP_WAIT : ST_CHECK;
      end
      ST_CHECK: begin
        cmd.fin      = 1'b1;
        cmd.fin_last = !(ended_r && !stat.empty);
        pend_nxt     = ended_r && !stat.empty;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = pend_r ? ST_START_WAIT : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ended_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ended_r <= ended_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_DECODE)
    else $error("accepted beat was not decoded");

  a_drop_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DROP |-> $past(state_r) == ST_DROP_WAIT)
    else $error("drop step without a ring read cycle");

  a_start_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START |-> $past(state_r) == ST_START_WAIT)
    else $error("start without a ring read cycle");

endmodule

@@ tb/testbench.sv @@
// Testbench for the I2C master transaction engine: drives command, load and bus status
// beats, predicts every result beat and compares it field by field as it is taken.
// Depends on i2cmte_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
  import i2cmte_pkg::*;

  localparam int QD = 8;
  localparam int MB = 16;
  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    cmd_t       command;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [4:0] byte_count;
    logic       send_stop;
    logic       linked_to_next;
    logic [3:0] load_index;
    logic [7:0] load_value;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } cmd_beat_t;

  typedef struct packed {
    action_t    bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
    outcome_t   outcome;
    logic [3:0] bytes_before_error;
    logic [7:0] bus_error_code;
    logic       notify;
    logic       enqueue_rejected;
    logic       last;
  } bus_step_t;

  class bus_step_board;
    desc_t      ring [QD];
    logic [7:0] wbytes [QD*MB];
    bit         wbyte_set [QD*MB];
    int         head, tail, active_slot, bytes_done;
    bit         busy;
    phase_t     phase;
    desc_t      active;
    bus_step_t  awaited_steps [$];
    int         mismatches, steps_checked, rejects, faults;

    function new();
      phase = PH_IDLE;
      active = '0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int ring_step(int p);
      return (p + 1) % QD;
    endfunction

    function bit ring_full();
      return ring_step(tail) == head;
    endfunction

    function bit slot_ready(int n);
      for (int i = 0; i < n; i++) begin
        if (!wbyte_set[tail*MB + i]) return 0;
      end
      return 1;
    endfunction

    function bit begin_next(output bus_step_t s);
      s = '0;
      if (head == tail) return 0;
      active_slot = head;
      active = ring[head];
      head = ring_step(head);
      busy = 1;
      bytes_done = 0;
      phase = PH_START;
      s.bus_action = ACT_START;
      return 1;
    endfunction

    function void fail_txn(inout bus_step_t s, input outcome_t code, input logic [7:0] st);
      bit chained;
      chained = active.link;
      s.bus_action = ACT_STOP;
      s.done_res = 1;
      s.outcome = code;
      s.bus_error_code = st;
      s.notify = 1;
      if (code == OC_DATA_FAIL) s.bytes_before_error = 4'(bytes_done - 1);
      while (chained && head != tail) begin
        chained = ring[head].link;
        head = ring_step(head);
      end
      busy = 0;
      phase = PH_IDLE;
      faults++;
    endfunction

    function void advance(inout bus_step_t s);
      if (bytes_done < active.count) begin
        phase = PH_DATA;
        if (!active.rw) begin
          s.bus_action = ACT_SEND;
          s.tx_byte = wbytes[active_slot*MB + bytes_done];
        end else begin
          s.bus_action = (bytes_done + 1 == active.count) ? ACT_RECV_NAK : ACT_RECV_ACK;
        end
        bytes_done++;
      end else begin
        s.bus_action = active.stop ? ACT_STOP : ACT_NONE;
        s.done_res = 1;
        s.notify = !active.link;
        busy = 0;
        phase = PH_IDLE;
      end
    endfunction

    function void bus_event(output bus_step_t s, input logic [7:0] raw, input logic [7:0] data);
      logic [7:0] st;
      logic       rw;
      st = raw & BS_MASK;
      rw = active.rw;
      s = '0;
      case (phase)
        PH_START: begin
          if (st != BS_START && st != BS_RESTART) begin
            fail_txn(s, OC_START_FAIL, st);
          end else begin
            phase = PH_ADDR;
            s.bus_action = ACT_SEND;
            s.tx_byte = {active.addr, rw};
          end
        end
        PH_ADDR: begin
          if (st != (rw ? BS_ADDR_R_ACK : BS_ADDR_W_ACK)) fail_txn(s, OC_ADDR_NACK, st);
          else advance(s);
        end
        default: begin
          if (rw ? (st != BS_DATA_RX_ACK && st != BS_DATA_RX_NACK) : (st != BS_DATA_TX_ACK)) begin
            fail_txn(s, OC_DATA_FAIL, st);
          end else begin
            if (rw) begin
              s.rx_valid = 1;
              s.rx_index = 4'(bytes_done - 1);
              s.rx_byte = data;
            end
            advance(s);
          end
        end
      endcase
    endfunction

    function void note_command(cmd_beat_t b);
      bus_step_t made [$];
      bus_step_t s;
      desc_t     d;
      s = '0;
      case (b.command)
        CMD_LOAD: begin
          if (b.load_index < MB && !(busy && tail == active_slot)) begin
            wbytes[tail*MB + b.load_index] = b.load_value;
            wbyte_set[tail*MB + b.load_index] = 1;
          end
        end
        CMD_ENQUEUE: begin
          if (ring_full()) begin
            s.enqueue_rejected = 1;
            rejects++;
          end else begin
            d.addr = b.target_address;
            d.rw = b.read_not_write;
            d.count = (b.byte_count > MB) ? 5'(MB) : b.byte_count;
            d.stop = b.send_stop;
            d.link = b.linked_to_next;
            ring[tail] = d;
            tail = ring_step(tail);
            if (!busy) void'(begin_next(s));
          end
          made.push_back(s);
        end
        CMD_EVENT: begin
          if (!busy) begin
            if (begin_next(s)) made.push_back(s);
          end else begin
            bus_event(s, b.bus_status, b.bus_data);
            made.push_back(s);
            if (!busy && begin_next(s)) made.push_back(s);
          end
        end
        default: ;
      endcase
      if (made.size() > 0) made[made.size()-1].last = 1;
      foreach (made[i]) awaited_steps.push_back(made[i]);
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_step(bus_step_t got);
      bus_step_t want;
      if (awaited_steps.size() == 0) begin
        $error("result beat arrived with no expected result pending");
        mismatches++;
        return;
      end
      want = awaited_steps.pop_front();
      steps_checked++;
      field_check("bus_action", want.bus_action, got.bus_action);
      field_check("tx_byte", want.tx_byte, got.tx_byte);
      field_check("rx_valid", want.rx_valid, got.rx_valid);
      field_check("rx_index", want.rx_index, got.rx_index);
      field_check("rx_byte", want.rx_byte, got.rx_byte);
      field_check("done_res", want.done_res, got.done_res);
      field_check("outcome", want.outcome, got.outcome);
      field_check("bytes_before_error", want.bytes_before_error, got.bytes_before_error);
      field_check("bus_error_code", want.bus_error_code, got.bus_error_code);
      field_check("notify", want.notify, got.notify);
      field_check("enqueue_rejected", want.enqueue_rejected, got.enqueue_rejected);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [6:0] in_target_address;
  logic       in_read_not_write;
  logic [4:0] in_byte_count;
  logic       in_send_stop;
  logic       in_linked_to_next;
  logic [3:0] in_load_index;
  logic [7:0] in_load_value;
  logic [7:0] in_bus_status;
  logic [7:0] in_bus_data;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_bus_action;
  logic [7:0] out_tx_byte;
  logic       out_rx_valid;
  logic [3:0] out_rx_index;
  logic [7:0] out_rx_byte;
  logic       out_done_res;
  logic [1:0] out_outcome;
  logic [3:0] out_bytes_before_error;
  logic [7:0] out_bus_error_code;
  logic       out_notify;
  logic       out_enqueue_rejected;
  logic       out_last;

  bus_step_board sb = new();
  int beats_sent = 0;
  int send_run = 0;
  int recv_run = 0;
  bit send_burst = 0;
  bit recv_burst = 0;
  bit hold_off = 0;

  i2c_master_transaction_engine #(
    .QUEUE_DEPTH(QD),
    .MAX_BYTES(MB)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_target_address(in_target_address),
    .in_read_not_write(in_read_not_write),
    .in_byte_count(in_byte_count),
    .in_send_stop(in_send_stop),
    .in_linked_to_next(in_linked_to_next),
    .in_load_index(in_load_index),
    .in_load_value(in_load_value),
    .in_bus_status(in_bus_status),
    .in_bus_data(in_bus_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bus_action(out_bus_action),
    .out_tx_byte(out_tx_byte),
    .out_rx_valid(out_rx_valid),
    .out_rx_index(out_rx_index),
    .out_rx_byte(out_rx_byte),
    .out_done_res(out_done_res),
    .out_outcome(out_outcome),
    .out_bytes_before_error(out_bytes_before_error),
    .out_bus_error_code(out_bus_error_code),
    .out_notify(out_notify),
    .out_enqueue_rejected(out_enqueue_rejected),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic cmd_beat_t noise_beat();
    cmd_beat_t b;
    b.command = 2'($urandom_range(0, 3));
    b.target_address = 7'($urandom_range(0, 127));
    b.read_not_write = 1'($urandom_range(0, 1));
    b.byte_count = 5'($urandom_range(0, 31));
    b.send_stop = 1'($urandom_range(0, 1));
    b.linked_to_next = 1'($urandom_range(0, 1));
    b.load_index = 4'($urandom_range(0, 15));
    b.load_value = 8'($urandom_range(0, 255));
    b.bus_status = 8'($urandom_range(0, 255));
    b.bus_data = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic drive_beat(cmd_beat_t b);
    int gap;
    if (send_run == 0) begin
      send_burst = ($urandom_range(0, 2) == 0);
      send_run = 24;
    end
    send_run--;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    {in_command, in_target_address, in_read_not_write, in_byte_count, in_send_stop,
     in_linked_to_next, in_load_index, in_load_value, in_bus_status, in_bus_data} = b;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_command(b);
    if (b.command != CMD_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic do_load(logic [3:0] idx, logic [7:0] val);
    cmd_beat_t b;
    b = noise_beat();
    b.command = CMD_LOAD;
    b.load_index = idx;
    b.load_value = val;
    drive_beat(b);
  endtask

  task automatic do_enqueue(logic [6:0] addr, logic rnw, logic [4:0] cnt, logic stop,
                            logic link);
    cmd_beat_t b;
    b = noise_beat();
    b.command = CMD_ENQUEUE;
    b.target_address = addr;
    b.read_not_write = rnw;
    b.byte_count = cnt;
    b.send_stop = stop;
    b.linked_to_next = link;
    drive_beat(b);
  endtask

  task automatic do_event(logic [7:0] status, logic [7:0] data);
    cmd_beat_t b;
    b = noise_beat();
    b.command = CMD_EVENT;
    b.bus_status = status;
    b.bus_data = data;
    drive_beat(b);
  endtask

  task automatic random_txn();
    logic [6:0] addr;
    logic [4:0] cnt;
    logic       rnw, stop, link;
    int         pick, eff;
    addr = 7'($urandom_range(0, 127));
    rnw = 1'($urandom_range(0, 1));
    stop = 1'($urandom_range(0, 1));
    link = ($urandom_range(0, 2) == 0);
    pick = $urandom_range(0, 99);
    cnt = (pick < 70) ? 5'($urandom_range(0, 4)) :
          (pick < 92) ? 5'($urandom_range(5, 16)) : 5'($urandom_range(17, 31));
    eff = (cnt > MB) ? MB : cnt;
    if (!rnw) begin
      for (int i = 0; i < eff; i++) begin
        if (!sb.wbyte_set[sb.tail*MB + i] || $urandom_range(0, 1))
          do_load(4'(i), 8'($urandom_range(0, 255)));
      end
    end
    if (!rnw && !sb.ring_full() && !sb.slot_ready(eff)) rnw = 1;
    do_enqueue(addr, rnw, cnt, stop, link);
  endtask

  task automatic random_noise();
    cmd_beat_t b;
    case ($urandom_range(0, 2))
      0: begin
        b = noise_beat();
        b.command = CMD_UNUSED;
        drive_beat(b);
      end
      1: do_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      default: do_event(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic logic [7:0] well_formed_status();
    logic [7:0] st;
    case (sb.phase)
      PH_START: st = $urandom_range(0, 1) ? BS_START : BS_RESTART;
      PH_ADDR: st = sb.active.rw ? BS_ADDR_R_ACK : BS_ADDR_W_ACK;
      default: begin
        if (!sb.active.rw) st = BS_DATA_TX_ACK;
        else st = $urandom_range(0, 1) ? BS_DATA_RX_ACK : BS_DATA_RX_NACK;
      end
    endcase
    return st | 8'($urandom_range(0, 7));
  endfunction

  initial begin : result_sink
    int gap;
    out_ready = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (recv_run == 0) begin
        recv_burst = ($urandom_range(0, 2) == 0);
        recv_run = 20;
      end
      recv_run--;
      gap = recv_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      while (hold_off) begin
        out_ready = 0;
        @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      sb.check_step({out_bus_action, out_tx_byte, out_rx_valid, out_rx_index, out_rx_byte,
                     out_done_res, out_outcome, out_bytes_before_error, out_bus_error_code,
                     out_notify, out_enqueue_rejected, out_last});
      @(negedge clk);
    end
  end

  initial begin
    wait (beats_sent >= 300);
    @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    cmd_beat_t b;
    int        pick;
    int        fill_left;
    fill_left = 0;
    rst_n = 0;
    in_valid = 0;
    {in_command, in_target_address, in_read_not_write, in_byte_count, in_send_stop,
     in_linked_to_next, in_load_index, in_load_value, in_bus_status, in_bus_data} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    do_event(BS_START, 8'h00);
    b = noise_beat();
    b.command = CMD_UNUSED;
    drive_beat(b);
    do_load(4'd0, 8'hFF);
    do_load(4'd1, 8'h00);
    do_load(4'd15, 8'hA5);
    do_enqueue(7'd127, 1'b0, 5'd2, 1'b1, 1'b0);
    do_event(BS_START | 8'h07, 8'h00);
    do_event(BS_ADDR_W_ACK, 8'hFF);
    do_event(BS_DATA_TX_ACK | 8'h07, 8'h00);
    do_event(BS_DATA_TX_ACK, 8'h00);
    do_enqueue(7'h55, 1'b1, 5'd20, 1'b0, 1'b1);
    do_enqueue(7'h2A, 1'b1, 5'd1, 1'b1, 1'b0);
    do_event(BS_RESTART, 8'h00);
    do_event(BS_ADDR_R_ACK, 8'h00);
    do_event(BS_DATA_RX_NACK, 8'hFF);
    do_event(8'h30, 8'h00);
    do_enqueue(7'd1, 1'b1, 5'd0, 1'b0, 1'b0);
    do_event(8'h00, 8'h00);
    do_enqueue(7'd2, 1'b0, 5'd0, 1'b1, 1'b0);
    do_event(BS_START, 8'h00);
    do_event(BS_ADDR_R_ACK, 8'h00);
    do_enqueue(7'd3, 1'b1, 5'd0, 1'b0, 1'b0);
    do_event(BS_START, 8'h00);
    do_event(BS_ADDR_R_ACK, 8'h00);

    while (beats_sent < 750) begin
      pick = $urandom_range(0, 99);
      if (fill_left > 0) begin
        if (sb.ring_full() && $urandom_range(0, 1))
          do_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        else
          random_txn();
        fill_left--;
      end else if (!sb.busy) begin
        if (pick < 90) random_txn();
        else random_noise();
      end else if (pick < 3) begin
        fill_left = 10;
      end else if (pick < 20) begin
        random_txn();
      end else if (pick < 24) begin
        random_noise();
      end else if (pick < 29) begin
        do_event(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        do_event(well_formed_status(), 8'($urandom_range(0, 255)));
      end
    end
    in_valid = 0;

    while (sb.awaited_steps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("tb: %0d beats sent, %0d result beats checked against the prediction",
             beats_sent, sb.steps_checked);
    $display("tb: %0d enqueues hit a full ring, %0d transfers ended in a bus fault",
             sb.rejects, sb.faults);
    if (sb.mismatches == 0 && sb.awaited_steps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
